FILE: rtl/wma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma_pkg: shared constants for the weighted moving average
// Register map indexes, field widths of the configuration registers and the
// width of the weight sum that the top level and the divider both use.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int unsigned TapsBits   = 3;
  localparam int unsigned WeightBits = 8;
  localparam int unsigned NumWeights = 4;
  // Four weights of 8 bits sum to at most 1020.
  localparam int unsigned WsumBits   = 10;

  localparam int unsigned AddrBits   = 5;
  localparam int unsigned DataBits   = 32;

  localparam logic [2:0] REG_TAPS = 3'd0;
  localparam logic [2:0] REG_W0   = 3'd1;
  localparam logic [2:0] REG_W1   = 3'd2;
  localparam logic [2:0] REG_W2   = 3'd3;
  localparam logic [2:0] REG_W3   = 3'd4;

  localparam logic [TapsBits-1:0]   TapsReset = 3'd4;
  localparam logic [WeightBits-1:0] W0Reset   = 8'd128;
  localparam logic [WeightBits-1:0] W1Reset   = 8'd77;
  localparam logic [WeightBits-1:0] W2Reset   = 8'd38;
  localparam logic [WeightBits-1:0] W3Reset   = 8'd13;

endpackage
`default_nettype wire

FILE: rtl/wma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma_div: restoring divider, one quotient bit per cycle
// Divides an unsigned magnitude by the weight sum; once the last quotient bit
// is in, busy_o falls and done_o is high for one cycle.
// ----------------------------------------------------------------------------
module wma_div #(
  parameter int unsigned DIVIDEND_W = 25
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [DIVIDEND_W-1:0]         dividend_i,
  input  wire  [wma_pkg::WsumBits-1:0]  divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [DIVIDEND_W-1:0]         quotient_o
);
  import wma_pkg::*;

  localparam int unsigned CntBits = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [WsumBits:0]     rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [WsumBits-1:0]   div_q, div_d;
  logic [WsumBits:0]     trial;
  logic                  fits;

  // The remainder stays below the divisor, so its low bits carry it whole.
  assign trial = {rem_q[WsumBits-1:0], quo_q[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, div_q}) : trial;
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTH
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with an empty bit count");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started during a run");
`endif

endmodule
`default_nettype wire

FILE: rtl/weighted_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_moving_average: weighted mean of the newest signed samples
// Keeps a ring of the last taps_in_use samples and returns, per sample, the
// weighted sum of the samples held so far divided by the sum of their weights.
// ----------------------------------------------------------------------------
// Usage. Samples arrive on the input channel (in_valid_i / in_stall_o /
// sample_i); one result leaves on the output channel (out_valid_o /
// out_stall_i / average_o, samples_used_o, no_weight_o) for every sample. A
// transaction completes on a rising edge where valid is high and stall low.
// The APB port writes taps_in_use at 0x0 and weight_0..weight_3 at 0x4..0x10;
// writing taps_in_use also empties the sample history. Write only when idle.
// Timing. After acceptance a sample passes through a multiply-accumulate
// step for each sample used (1 to 4), a step that starts the division, the
// bit-serial divider, which finds the quotient bit by bit and then signals
// done, and a load of the output register. The input stalls until the result
// is loaded, and the next sample can be taken in the cycle after that load.
// When the weights used sum to zero the divider is skipped and 0 is returned
// with no_weight_o set.
// Stall. The finished result waits in the output register, and the next
// sample is taken meanwhile; a further result holds in its done state until
// the output register is free. Reset empties the history and restores the
// register defaults (taps 4, weights 128, 77, 38, 13).
// ----------------------------------------------------------------------------
module weighted_moving_average #(
  parameter int unsigned MAX_TAPS    = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [wma_pkg::AddrBits-1:0]     paddr,
  input  wire  [wma_pkg::DataBits-1:0]     pwdata,
  output logic [wma_pkg::DataBits-1:0]     prdata,
  output logic                             pready,
  // Sample input
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0]    sample_i,
  // Result output
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    average_o,
  output logic [wma_pkg::TapsBits-1:0]     samples_used_o,
  output logic                             no_weight_o
);
  import wma_pkg::*;

  localparam int unsigned PosBits  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned ProdBits = SAMPLE_BITS + WeightBits + 1;
  localparam int unsigned AccBits  = SAMPLE_BITS + WsumBits;
  localparam int unsigned MagBits  = AccBits - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Configuration registers
  logic [TapsBits-1:0]   taps_q;
  logic [WeightBits-1:0] weight_q [NumWeights];
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  // Sample history and ring bookkeeping
  logic [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];
  logic [PosBits-1:0]     wp_q;
  logic [TapsBits-1:0]    seen_q;
  logic [TapsBits-1:0]    taps_eff;
  logic [PosBits-1:0]     wp_eff;
  logic [TapsBits-1:0]    seen_next;
  logic                   in_acc;

  // Sequencer and datapath
  logic [2:0]               state_q, state_d;
  logic [PosBits-1:0]       rd_q;
  logic [TapsBits-1:0]      step_q;
  logic [TapsBits-1:0]      used_q;
  logic signed [AccBits-1:0] acc_q;
  logic [WsumBits-1:0]      wsum_q;
  logic signed [ProdBits-1:0] prod;
  logic                     neg_q;
  logic [MagBits-1:0]       mag;
  logic [AccBits-1:0]       acc_abs;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [MagBits-1:0]       div_quo;
  logic [SAMPLE_BITS-1:0]   quo_trunc;
  logic [SAMPLE_BITS-1:0]   res_avg_q;
  logic                     res_flag_q;

  // Output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic [TapsBits-1:0]    out_used_q;
  logic                   out_flag_q;
  logic                   out_load;

  // --------------------------------------------------------------------------
  // Configuration port. Register i sits at byte address 4*i.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrBits-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_TAPS: prdata = DataBits'(taps_q);
      REG_W0:   prdata = DataBits'(weight_q[0]);
      REG_W1:   prdata = DataBits'(weight_q[1]);
      REG_W2:   prdata = DataBits'(weight_q[2]);
      REG_W3:   prdata = DataBits'(weight_q[3]);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q      <= TapsReset;
      weight_q[0] <= W0Reset;
      weight_q[1] <= W1Reset;
      weight_q[2] <= W2Reset;
      weight_q[3] <= W3Reset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TAPS: taps_q      <= pwdata[TapsBits-1:0];
        REG_W0:   weight_q[0] <= pwdata[WeightBits-1:0];
        REG_W1:   weight_q[1] <= pwdata[WeightBits-1:0];
        REG_W2:   weight_q[2] <= pwdata[WeightBits-1:0];
        REG_W3:   weight_q[3] <= pwdata[WeightBits-1:0];
        default: ;
      endcase
    end
  end

  // A tap count of zero acts as one; anything above the ring depth acts as
  // the full ring. The register keeps the bits as written.
  always_comb begin
    taps_eff = taps_q;
    if (taps_q == '0) begin
      taps_eff = TapsBits'(1);
    end else if (taps_q > TapsBits'(MAX_TAPS)) begin
      taps_eff = TapsBits'(MAX_TAPS);
    end
  end

  // --------------------------------------------------------------------------
  // Ring write at acceptance. The sample count saturates at the tap count.
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wp_eff    = (TapsBits'(wp_q) >= taps_eff) ? '0 : wp_q;
  assign seen_next = (seen_q < taps_eff) ? (seen_q + TapsBits'(1)) : taps_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cfg_wr && (cfg_idx == REG_TAPS)) begin
      wp_q   <= '0;
      seen_q <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (in_acc) begin
      hist_q[wp_eff] <= sample_i;
      wp_q   <= ((TapsBits'(wp_eff) + TapsBits'(1)) == taps_eff) ?
                '0 : (wp_eff + PosBits'(1));
      seen_q <= seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate: one stored sample per cycle, newest first.
  // --------------------------------------------------------------------------
  assign prod = $signed(hist_q[rd_q]) * $signed({1'b0, weight_q[step_q[1:0]]});

  assign acc_abs   = acc_q[AccBits-1] ? (~acc_q + AccBits'(1)) : acc_q;
  assign mag       = acc_abs[MagBits-1:0];
  assign div_start = (state_q == S_DIVS) && (wsum_q != '0);
  assign quo_trunc = div_quo[SAMPLE_BITS-1:0];

  wma_div #(
    .DIVIDEND_W (MagBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (wsum_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_MAC;
      S_MAC:  if ((step_q + TapsBits'(1)) == used_q) state_d = S_DIVS;
      S_DIVS: state_d = (wsum_q == '0) ? S_DONE : S_DIVW;
      S_DIVW: if (div_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rd_q   <= wp_eff;
        step_q <= '0;
        used_q <= seen_next;
        acc_q  <= '0;
        wsum_q <= '0;
      end
      S_MAC: begin
        acc_q  <= acc_q + {{(AccBits - ProdBits){prod[ProdBits-1]}}, prod};
        wsum_q <= wsum_q + WsumBits'(weight_q[step_q[1:0]]);
        step_q <= step_q + TapsBits'(1);
        // Step back through the ring, wrapping to its last slot in use.
        rd_q   <= (rd_q == '0) ? PosBits'(taps_eff - TapsBits'(1)) :
                                 (rd_q - PosBits'(1));
      end
      S_DIVS: begin
        neg_q      <= acc_q[AccBits-1];
        res_avg_q  <= '0;
        res_flag_q <= (wsum_q == '0);
      end
      S_DIVW: begin
        if (div_done) begin
          res_avg_q <= neg_q ? (~quo_trunc + SAMPLE_BITS'(1)) : quo_trunc;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: holds a result while the receiver stalls.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q  <= res_avg_q;
      out_used_q <= used_q;
      out_flag_q <= res_flag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = out_avg_q;
  assign samples_used_o = out_used_q;
  assign no_weight_o    = out_flag_q;

`ifndef SYNTH
  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (step_q < used_q))
    else $error("accumulate step ran past the samples in use");
  a_div_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW) |-> (div_busy || div_done))
    else $error("waiting on a divider that is not running");
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= taps_eff)
    else $error("sample count exceeds the tap count");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_flag_q) |-> (out_avg_q == '0))
    else $error("zero weight sum with a nonzero average");
`endif

endmodule
`default_nettype wire
